/* src/mlp_train_and_infer_macros.svh */
// Assertion helpers for the perceptron block.
`ifndef MLP_TRAIN_AND_INFER_MACROS_SVH
`define MLP_TRAIN_AND_INFER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define MLP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MLP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* src/mlp_pkg.sv */
package mlp_pkg;
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_INFER = 2'd2,
    CMD_TRAIN = 2'd3
  } cmd_t;

  localparam int QW = 16;
  localparam logic signed [15:0] ONE_Q = 16'sd4096;
  localparam logic [12:0] LR_RESET = 13'd205;
  localparam logic signed [15:0] TANH_SAT = 16'sd4093;

  function automatic logic [11:0] tanh_knot(input logic [4:0] i);
    case (i)
      5'd0: tanh_knot = 12'd0;
      5'd1: tanh_knot = 12'd1003;
      5'd2: tanh_knot = 12'd1893;
      5'd3: tanh_knot = 12'd2602;
      5'd4: tanh_knot = 12'd3119;
      5'd5: tanh_knot = 12'd3475;
      5'd6: tanh_knot = 12'd3707;
      5'd7: tanh_knot = 12'd3856;
      5'd8: tanh_knot = 12'd3949;
      5'd9: tanh_knot = 12'd4006;
      5'd10: tanh_knot = 12'd4041;
      5'd11: tanh_knot = 12'd4062;
      5'd12: tanh_knot = 12'd4076;
      5'd13: tanh_knot = 12'd4084;
      5'd14: tanh_knot = 12'd4089;
      5'd15: tanh_knot = 12'd4091;
      default: tanh_knot = 12'd4093;
    endcase
  endfunction

  // Saturate a wide signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) sat16 = 16'sh7fff;
    else if (v < -48'sd32768) sat16 = -16'sh8000;
    else sat16 = v[15:0];
  endfunction

  // Round a Q-product back to Q4.12: floor((v + 2048) / 4096).
  function automatic logic signed [47:0] rnd12(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = v + 48'sd2048;
    rnd12 = t >>> 12;
  endfunction
endpackage

/* src/mlp_train_and_infer.sv */
// Tanh perceptron (3 inputs, NUM_HIDDEN hidden nodes, 1 output) with on-chip
// parameter store and online SGD training.
// Input channel in_*: tdata = {target, feature_2, feature_1, feature_0,
// param_value, param_index, command} from the lowest bit. A transfer starts
// one command; in_tready is high only while the sequencer is idle.
// Output channel out_*: tdata = {bad_index, read_value, squared_error,
// prediction}. Exactly one result per command.
// Write and read go straight to the done state; infer and train step through
// the accumulate, tanh and (for train) error, delta and update states, since
// every multiply, including the tanh interpolation, goes through the one
// shared 32x32 multiplier, one per cycle.
// The next command is taken the cycle after a result is registered.
// Reset zeroes the parameter store at once and returns the learning rate to 205.
// When the receiver stalls, the result waits in the output register; the next
// command is still taken and computed, then waits in its last state until the
// register is free, which holds off further commands.
// cfg_* writes the 13-bit learning rate; it is taken only while idle.
module mlp_train_and_infer
  import mlp_pkg::*;
#(
  parameter int NUM_HIDDEN = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[1:0], param_index[6:2], param_value[22:7], feature_0[35:23],
  // feature_1[48:36], feature_2[61:49], target[74:62], zero pad
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // prediction[13:0], squared_error[28:14], read_value[44:29], bad_index[45]
  output logic [47:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);
  `include "mlp_train_and_infer_macros.svh"

  localparam int NI = 3;
  localparam int HB = NI * NUM_HIDDEN;
  localparam int OW = HB + NUM_HIDDEN;
  localparam int OB = OW + NUM_HIDDEN;
  localparam int NP = OB + 1;
  localparam int AW = $clog2(NP + 1);
  localparam int HW = $clog2(NUM_HIDDEN + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_HACC  = 11'b00000000010, // hidden node accumulate (bias + 3 products)
    S_TANH  = 11'b00000000100, // interpolation multiply
    S_OACC  = 11'b00000001000, // output accumulate
    S_ERR   = 11'b00000010000, // err^2 and y^2
    S_DOUT  = 11'b00000100000, // dout, learn-rate gradient
    S_DH    = 11'b00001000000, // hidden deltas
    S_UOUT  = 11'b00010000000, // output weight updates
    S_UHID  = 11'b00100000000, // hidden updates
    S_DONE  = 11'b01000000000,
    S_HDH   = 11'b10000000000  // h^2 for hidden delta
  } st_t;

  st_t st_r, st_nxt;
  logic signed [15:0] store_r [NP];
  logic signed [15:0] h_r [NUM_HIDDEN];
  logic signed [15:0] dh_r [NUM_HIDDEN];
  logic [12:0] lr_r;
  logic [1:0] cmd_r;
  logic [4:0] idx_r;
  logic signed [15:0] pv_r;
  logic [12:0] x_r [NI];
  logic [12:0] tgt_r;
  logic signed [47:0] acc_r;
  logic [HW-1:0] j_r;
  logic [2:0] k_r;
  logic [2:0] ph_r;          // sub-step inside a state
  logic signed [15:0] y_r, dout_r, g_r, t_r, tsrc_r;
  logic [14:0] sq_r;
  logic tret_r;              // 0: tanh result goes to hidden node, 1: to output
  logic ovalid_r;
  logic [47:0] odata_r;

  // shared multiplier
  logic signed [31:0] ma, mb;
  logic signed [63:0] mp;
  logic signed [47:0] mp48, mr;
  assign mp = ma * mb;
  assign mp48 = mp[47:0];
  assign mr = rnd12(mp48);

  logic [12:0] fx0, fx1, fx2, ftg;
  logic [1:0] fcmd;
  logic [4:0] fidx;
  assign fcmd = in_tdata[1:0];
  assign fidx = in_tdata[6:2];
  assign fx0 = in_tdata[35:23];
  assign fx1 = in_tdata[48:36];
  assign fx2 = in_tdata[61:49];
  assign ftg = in_tdata[74:62];

  assign in_tready = (st_r == S_IDLE);
  assign cfg_ready = (st_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;

  // tanh helper on the source value
  logic [15:0] tabs;
  logic tbig;
  logic [3:0] tseg;
  logic [9:0] tfrac;
  logic [11:0] tk0, tk1;
  assign tabs = tsrc_r[15] ? 16'(-tsrc_r) : 16'(tsrc_r);
  assign tbig = tabs >= 16'd16384;
  assign tseg = tabs[13:10];
  assign tfrac = tabs[9:0];
  assign tk0 = tanh_knot({1'b0, tseg});
  assign tk1 = tanh_knot({1'b0, tseg} + 5'd1);

  logic [AW-1:0] hw_addr, ow_addr, hb_addr, hb_next;
  logic [4:0] kk;
  always_comb begin
    kk = 5'(k_r);
    hw_addr = AW'(32'(kk) * NUM_HIDDEN + 32'(j_r));
    ow_addr = AW'(OW + 32'(j_r));
    hb_addr = AW'(HB + 32'(j_r));
    hb_next = AW'(HB + 32'(j_r) + 1);
  end

  // multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_r)
      S_HACC: begin
        ma = 32'(signed'({19'd0, x_r[k_r[1:0]]}));
        mb = 32'(store_r[hw_addr]);
      end
      S_TANH: begin
        ma = 32'(signed'({20'd0, tk1 - tk0}));
        mb = 32'(signed'({22'd0, tfrac}));
      end
      S_OACC: begin
        ma = 32'(h_r[j_r]);
        mb = 32'(store_r[ow_addr]);
      end
      S_ERR: begin
        ma = (ph_r == 3'd0) ? 32'(signed'({19'd0, tgt_r})) - 32'(y_r) : 32'(y_r);
        mb = (ph_r == 3'd0) ? 32'(signed'({19'd0, tgt_r})) - 32'(y_r) : 32'(y_r);
      end
      S_DOUT: begin
        ma = (ph_r == 3'd0) ? 32'(signed'({19'd0, tgt_r})) - 32'(y_r) : 32'(dout_r);
        mb = (ph_r == 3'd0) ? 32'(t_r) : 32'(signed'({19'd0, lr_r}));
      end
      S_HDH: begin
        ma = 32'(h_r[j_r]);
        mb = 32'(h_r[j_r]);
      end
      S_DH: begin
        ma = (ph_r == 3'd0) ? 32'(dout_r) : 32'(t_r);
        mb = (ph_r == 3'd0) ? 32'(store_r[ow_addr]) : 32'(tsrc_r);
      end
      S_UOUT: begin
        ma = 32'(h_r[j_r]);
        mb = 32'(g_r);
      end
      S_UHID: begin
        ma = (ph_r == 3'd0) ? 32'(dh_r[j_r]) : 32'(signed'({19'd0, x_r[k_r[1:0]]}));
        mb = (ph_r == 3'd0) ? 32'(signed'({19'd0, lr_r})) : 32'(g_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  logic signed [15:0] tanh_y;
  logic signed [47:0] interp;
  always_comb begin
    interp = 48'(signed'({36'd0, tk0})) + ((mp48 + 48'sd512) >>> 10);
    if (tbig) tanh_y = TANH_SAT;
    else tanh_y = interp[15:0];
    if (tsrc_r[15]) tanh_y = -tanh_y;
  end

  logic signed [47:0] hsum;
  always_comb hsum = 48'(acc_r) + 48'(mp48);

  // Result word of the finishing command; it moves to the output register
  // once that register is free or being emptied.
  logic [AW-1:0] idx_addr;
  logic idx_bad;
  logic done_go;
  logic [47:0] done_data;
  always_comb begin
    idx_addr = AW'(idx_r);
    idx_bad = 32'(idx_r) >= NP;
    done_data = '0;
    if (cmd_t'(cmd_r) == CMD_WRITE || cmd_t'(cmd_r) == CMD_READ) begin
      done_data[45] = idx_bad;
      if (!idx_bad && cmd_t'(cmd_r) == CMD_READ) done_data[44:29] = store_r[idx_addr];
    end else begin
      done_data[13:0] = y_r[13:0];
      done_data[28:14] = sq_r;
    end
  end
  assign done_go = !ovalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ovalid_r <= 1'b0;
      lr_r <= LR_RESET;
      for (int i = 0; i < NP; i++) store_r[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) lr_r <= cfg_data;
      if (st_r == S_DONE && done_go) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            cmd_r <= fcmd;
            idx_r <= fidx;
            pv_r <= in_tdata[22:7];
            x_r[0] <= fx0;
            x_r[1] <= fx1;
            x_r[2] <= fx2;
            tgt_r <= ftg;
            y_r <= '0;
            sq_r <= '0;
            j_r <= '0;
            k_r <= '0;
            ph_r <= '0;
            if (cmd_t'(fcmd) == CMD_WRITE || cmd_t'(fcmd) == CMD_READ) begin
              st_r <= S_DONE;
            end else begin
              acc_r <= 48'(store_r[HB]) <<< 12;
              st_r <= S_HACC;
            end
          end
        end
        S_HACC: begin
          if (k_r == 3'd2) begin
            tsrc_r <= sat16(rnd12(hsum));
            tret_r <= 1'b0;
            st_r <= S_TANH;
            k_r <= '0;
          end else begin
            acc_r <= hsum;
            k_r <= k_r + 3'd1;
          end
        end
        S_TANH: begin
          if (!tret_r) begin
            h_r[j_r] <= tanh_y;
            if (32'(j_r) == NUM_HIDDEN - 1) begin
              j_r <= '0;
              acc_r <= 48'(store_r[OB]) <<< 12;
              st_r <= S_OACC;
            end else begin
              j_r <= j_r + 1'b1;
              acc_r <= 48'(store_r[hb_next]) <<< 12;
              st_r <= S_HACC;
            end
          end else begin
            y_r <= tanh_y;
            st_r <= (cmd_t'(cmd_r) == CMD_TRAIN) ? S_ERR : S_DONE;
          end
        end
        S_OACC: begin
          if (32'(j_r) == NUM_HIDDEN - 1) begin
            tsrc_r <= sat16(rnd12(hsum));
            tret_r <= 1'b1;
            j_r <= '0;
            st_r <= S_TANH;
          end else begin
            acc_r <= hsum;
            j_r <= j_r + 1'b1;
          end
        end
        S_ERR: begin
          if (ph_r == 3'd0) begin
            sq_r <= (mr > 48'sd32767) ? 15'h7fff : mr[14:0];
            ph_r <= 3'd1;
          end else begin
            t_r <= 16'(ONE_Q - mr[15:0]);
            ph_r <= 3'd0;
            st_r <= S_DOUT;
          end
        end
        S_DOUT: begin
          if (ph_r == 3'd0) begin
            dout_r <= sat16(mr);
            ph_r <= 3'd1;
          end else begin
            g_r <= sat16(mr);
            ph_r <= 3'd0;
            j_r <= '0;
            st_r <= S_HDH;
          end
        end
        S_HDH: begin
          tsrc_r <= 16'(ONE_Q - mr[15:0]);
          st_r <= S_DH;
        end
        S_DH: begin
          if (ph_r == 3'd0) begin
            t_r <= sat16(mr);
            ph_r <= 3'd1;
          end else begin
            dh_r[j_r] <= sat16(mr);
            ph_r <= 3'd0;
            if (32'(j_r) == NUM_HIDDEN - 1) begin
              j_r <= '0;
              store_r[OB] <= sat16(48'(store_r[OB]) + 48'(g_r));
              st_r <= S_UOUT;
            end else begin
              j_r <= j_r + 1'b1;
              st_r <= S_HDH;
            end
          end
        end
        S_UOUT: begin
          store_r[ow_addr] <= sat16(48'(store_r[ow_addr]) + mr);
          if (32'(j_r) == NUM_HIDDEN - 1) begin
            j_r <= '0;
            ph_r <= 3'd0;
            st_r <= S_UHID;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_UHID: begin
          if (ph_r == 3'd0) begin
            g_r <= sat16(mr);
            store_r[hb_addr] <= sat16(48'(store_r[hb_addr]) + 48'(sat16(mr)));
            k_r <= '0;
            ph_r <= 3'd1;
          end else begin
            store_r[hw_addr] <= sat16(48'(store_r[hw_addr]) + mr);
            if (k_r == 3'd2) begin
              ph_r <= 3'd0;
              k_r <= '0;
              if (32'(j_r) == NUM_HIDDEN - 1) st_r <= S_DONE;
              else j_r <= j_r + 1'b1;
            end else begin
              k_r <= k_r + 3'd1;
            end
          end
        end
        S_DONE: begin
          if (done_go) begin
            odata_r <= done_data;
            if (cmd_t'(cmd_r) == CMD_WRITE && !idx_bad) store_r[idx_addr] <= pv_r;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `MLP_ASSERT_IMP(a_busy_not_ready, st_r != S_IDLE, !in_tready)
  `MLP_ASSERT_NXT(a_done_gives_result, st_r == S_DONE, out_tvalid)
  `MLP_ASSERT_NXT(a_stall_holds, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule
